// File: rtl/rde_pkg.sv
// ----------------------------------------------------------------------------
// rde_pkg
// shared constants, types and tables for the radix digit emitter
// ----------------------------------------------------------------------------
package rde_pkg;

  localparam int unsigned INT_BITS        = 31;
  localparam int unsigned MAX_FRAC_DIGITS = 10;
  localparam int unsigned FRAC_BITS       = 32;
  localparam int unsigned BASE_BITS       = 5;
  localparam int unsigned DIGIT_BITS      = 4;
  localparam int unsigned CHAR_BITS       = 7;

  localparam logic [FRAC_BITS-1:0] FRAC_EPS = FRAC_BITS'(42);
  localparam logic [BASE_BITS-1:0] BASE_MIN = BASE_BITS'(2);
  localparam logic [BASE_BITS-1:0] BASE_MAX = BASE_BITS'(16);

  localparam int unsigned STACK_DEPTH = INT_BITS;
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned FCNT_W      = $clog2(MAX_FRAC_DIGITS + 1);

  // reciprocal precision, one bit beyond the integer width
  localparam int unsigned RW     = INT_BITS + 1;
  localparam int unsigned PROD_W = INT_BITS + RW;

  localparam logic [RW:0] POW = {1'b1, {RW{1'b0}}};

  // floor(2^RW / b), entries below two are never selected
  localparam logic [RW-1:0] RECIP [17] = '{
    RW'(POW / 2),  RW'(POW / 2),  RW'(POW / 2),  RW'(POW / 3),
    RW'(POW / 4),  RW'(POW / 5),  RW'(POW / 6),  RW'(POW / 7),
    RW'(POW / 8),  RW'(POW / 9),  RW'(POW / 10), RW'(POW / 11),
    RW'(POW / 12), RW'(POW / 13), RW'(POW / 14), RW'(POW / 15),
    RW'(POW / 16)
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_POP,
    ST_FRAC
  } state_e;

  function automatic logic [CHAR_BITS-1:0] to_ascii(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] c;
    if (d < DIGIT_BITS'(10)) begin
      c = CHAR_BITS'(7'h30) + CHAR_BITS'(d);
    end else begin
      c = CHAR_BITS'(7'h41) + CHAR_BITS'(d - DIGIT_BITS'(10));
    end
    return c;
  endfunction

endpackage

// File: rtl/radix_digit_emitter.sv
// ----------------------------------------------------------------------------
// radix_digit_emitter
// converts an integer part and a Q0.32 fraction into ASCII digits of radix 2..16
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                    payload
// command   in         start_i while busy_o low     int_value_i, frac_value_i, base_i
// result    out        result_valid_o, one cycle    digit_char_o, frac_part_o, last_digit_o
//
// each integer digit passes through the reciprocal multiplier (multiply, then
// correct and push) and is later popped from the digit stack, plus a final
// step to drain the stack read; each fraction digit comes from a separate
// multiply of the fraction by the base.
// a conversion keeps busy_o high until its last fraction digit is computed. reset
// clears the sequencer only. results cannot be held off: each one stands on the
// ports for exactly one cycle.
//
module radix_digit_emitter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [rde_pkg::INT_BITS-1:0]         int_value_i,
  input  logic [rde_pkg::FRAC_BITS-1:0]        frac_value_i,
  input  logic [rde_pkg::BASE_BITS-1:0]        base_i,
  output logic                                 result_valid_o,
  output logic [rde_pkg::CHAR_BITS-1:0]        digit_char_o,
  output logic                                 frac_part_o,
  output logic                                 last_digit_o
);

  rde_pkg::state_e state_q, state_d;

  logic [rde_pkg::INT_BITS-1:0]   val_q, val_d;
  logic [rde_pkg::FRAC_BITS-1:0]  frac_q, frac_d;
  logic [rde_pkg::BASE_BITS-1:0]  base_q, base_d;
  logic [rde_pkg::PROD_W-1:0]     prod_q, prod_d;
  logic [rde_pkg::SP_W-1:0]       sp_q, sp_d;
  logic                           pop_vld_q, pop_vld_d;
  logic [rde_pkg::FCNT_W-1:0]     fcnt_q, fcnt_d;

  logic                           vld_q, vld_d;
  logic [rde_pkg::CHAR_BITS-1:0]  char_q, char_d;
  logic                           fpart_q, fpart_d;
  logic                           last_q, last_d;

  logic [rde_pkg::DIGIT_BITS-1:0] stack_mem [rde_pkg::STACK_DEPTH];
  logic [rde_pkg::DIGIT_BITS-1:0] rd_q;
  logic [rde_pkg::IDX_W-1:0]      rd_addr;
  logic                           push;
  logic [rde_pkg::DIGIT_BITS-1:0] push_digit;

  // divide step
  logic [rde_pkg::INT_BITS-1:0]           q_est;
  logic [rde_pkg::INT_BITS+rde_pkg::BASE_BITS-1:0] qb;
  logic [rde_pkg::INT_BITS-1:0]           rem_full;
  logic [rde_pkg::BASE_BITS-1:0]          rem_lo;
  logic                                   rem_ovf;
  logic [rde_pkg::INT_BITS-1:0]           q_fix;
  logic [rde_pkg::DIGIT_BITS-1:0]         int_digit;

  // fraction step
  logic [rde_pkg::FRAC_BITS+rde_pkg::BASE_BITS-1:0] fprod;
  logic [rde_pkg::FRAC_BITS-1:0]          frac_next;
  logic [rde_pkg::DIGIT_BITS-1:0]         frac_digit;
  logic [rde_pkg::FCNT_W-1:0]             fcnt_inc;
  logic                                   frac_more;

  logic [rde_pkg::BASE_BITS-1:0]          base_clamp;

  assign busy_o         = (state_q != rde_pkg::ST_IDLE);
  assign result_valid_o = vld_q;
  assign digit_char_o   = char_q;
  assign frac_part_o    = fpart_q;
  assign last_digit_o   = last_q;

  always_comb begin
    if (base_i < rde_pkg::BASE_MIN) begin
      base_clamp = rde_pkg::BASE_MIN;
    end else if (base_i > rde_pkg::BASE_MAX) begin
      base_clamp = rde_pkg::BASE_MAX;
    end else begin
      base_clamp = base_i;
    end
  end

  // quotient estimate is exact or one low
  assign q_est    = prod_q[rde_pkg::PROD_W-1:rde_pkg::RW];
  assign qb       = q_est * base_q;
  assign rem_full = val_q - qb[rde_pkg::INT_BITS-1:0];
  assign rem_lo   = rem_full[rde_pkg::BASE_BITS-1:0];
  assign rem_ovf  = (rem_lo >= base_q);
  assign q_fix    = rem_ovf ? (q_est + rde_pkg::INT_BITS'(1)) : q_est;
  assign int_digit = rem_ovf ? rde_pkg::DIGIT_BITS'(rem_lo - base_q)
                             : rde_pkg::DIGIT_BITS'(rem_lo);

  assign fprod      = frac_q * base_q;
  assign frac_next  = fprod[rde_pkg::FRAC_BITS-1:0];
  assign frac_digit = fprod[rde_pkg::FRAC_BITS+rde_pkg::DIGIT_BITS-1:rde_pkg::FRAC_BITS];
  assign fcnt_inc   = fcnt_q + rde_pkg::FCNT_W'(1);
  assign frac_more  = (frac_next > rde_pkg::FRAC_EPS) &&
                      (fcnt_inc < rde_pkg::FCNT_W'(rde_pkg::MAX_FRAC_DIGITS));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rde_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = rde_pkg::ST_MUL;
        end
      end
      rde_pkg::ST_MUL: begin
        state_d = rde_pkg::ST_DIV;
      end
      rde_pkg::ST_DIV: begin
        state_d = (q_fix == '0) ? rde_pkg::ST_POP : rde_pkg::ST_MUL;
      end
      rde_pkg::ST_POP: begin
        if (sp_q == '0) begin
          state_d = rde_pkg::ST_FRAC;
        end
      end
      rde_pkg::ST_FRAC: begin
        if (!frac_more) begin
          state_d = rde_pkg::ST_IDLE;
        end
      end
      default: state_d = rde_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    val_d      = val_q;
    frac_d     = frac_q;
    base_d     = base_q;
    prod_d     = prod_q;
    sp_d       = sp_q;
    pop_vld_d  = 1'b0;
    fcnt_d     = fcnt_q;
    vld_d      = 1'b0;
    char_d     = char_q;
    fpart_d    = fpart_q;
    last_d     = last_q;
    push       = 1'b0;
    push_digit = int_digit;
    rd_addr    = '0;
    unique case (state_q)
      rde_pkg::ST_IDLE: begin
        if (start_i) begin
          val_d  = int_value_i;
          frac_d = frac_value_i;
          base_d = base_clamp;
          sp_d   = '0;
          fcnt_d = '0;
        end
      end
      rde_pkg::ST_MUL: begin
        prod_d = val_q * rde_pkg::RECIP[base_q];
      end
      rde_pkg::ST_DIV: begin
        push  = 1'b1;
        val_d = q_fix;
        sp_d  = sp_q + rde_pkg::SP_W'(1);
      end
      rde_pkg::ST_POP: begin
        if (sp_q != '0) begin
          rd_addr   = rde_pkg::IDX_W'(sp_q - rde_pkg::SP_W'(1));
          sp_d      = sp_q - rde_pkg::SP_W'(1);
          pop_vld_d = 1'b1;
        end
        if (pop_vld_q) begin
          vld_d   = 1'b1;
          char_d  = rde_pkg::to_ascii(rd_q);
          fpart_d = 1'b0;
          last_d  = 1'b0;
        end
      end
      rde_pkg::ST_FRAC: begin
        frac_d  = frac_next;
        fcnt_d  = fcnt_inc;
        vld_d   = 1'b1;
        char_d  = rde_pkg::to_ascii(frac_digit);
        fpart_d = 1'b1;
        last_d  = !frac_more;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_mem[sp_q[rde_pkg::IDX_W-1:0]] <= push_digit;
    end
    rd_q <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rde_pkg::ST_IDLE;
      sp_q      <= '0;
      pop_vld_q <= 1'b0;
      fcnt_q    <= '0;
      vld_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      sp_q      <= sp_d;
      pop_vld_q <= pop_vld_d;
      fcnt_q    <= fcnt_d;
      vld_q     <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    frac_q  <= frac_d;
    base_q  <= base_d;
    prod_q  <= prod_d;
    char_q  <= char_d;
    fpart_q <= fpart_d;
    last_q  <= last_d;
  end

endmodule
